@@ design/bpc_pkg.sv @@
// Package with shared types and constants for the button press classifier.
package bpc_pkg;

  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_POLL = 1'b1;

  localparam logic PRESS_SHORT = 1'b0;
  localparam logic PRESS_LONG  = 1'b1;

  localparam logic REG_DEBOUNCE   = 1'b0;
  localparam logic REG_LONG_PRESS = 1'b1;

  localparam logic [15:0] DEBOUNCE_RESET   = 16'd30;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd800;

  typedef struct packed {
    logic        kind;
    logic [31:0] now_ms;
    logic        pin_level;
  } item_t;

  typedef struct packed {
    logic  fire;
    item_t item;
  } stage_t;

  typedef struct packed {
    logic valid;
    logic press_event;
  } result_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
  } cfg_t;

endpackage

@@ design/bpc_if.sv @@
// Channel interfaces for sample items and press result items.
interface bpc_sample_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] now_ms;
  logic        pin_level;

  modport source(output valid, kind, now_ms, pin_level, input ready);
  modport sink(input valid, kind, now_ms, pin_level, output ready);
endinterface

interface bpc_press_if;
  logic valid;
  logic ready;
  logic press_event;

  modport source(output valid, press_event, input ready);
  modport sink(input valid, press_event, output ready);
endinterface

@@ design/bpc_cfg.sv @@
// APB register block holding the debounce and long press thresholds.
module bpc_cfg
  import bpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [15:0] debounce_ms;
  logic [15:0] long_press_ms;
  logic        wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms   <= DEBOUNCE_RESET;
      long_press_ms <= LONG_PRESS_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_DEBOUNCE:   debounce_ms   <= pwdata[15:0];
        REG_LONG_PRESS: long_press_ms <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DEBOUNCE:   prdata = {16'd0, debounce_ms};
      REG_LONG_PRESS: prdata = {16'd0, long_press_ms};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg.debounce_ms   = debounce_ms;
  assign cfg.long_press_ms = long_press_ms;

endmodule

@@ design/bpc_in_stage.sv @@
// Input register that holds one sample item until the core takes it.
module bpc_in_stage
  import bpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  bpc_sample_if.sink        sample,
  input  logic              out_free,
  output stage_t            stage
);

  logic  valid;
  item_t item;
  logic  fire;

  assign fire         = valid && out_free;
  assign sample.ready = !valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sample.ready) begin
      valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      item.kind      <= sample.kind;
      item.now_ms    <= sample.now_ms;
      item.pin_level <= sample.pin_level;
    end
  end

  assign stage.fire = fire;
  assign stage.item = item;

endmodule

@@ design/bpc_core.sv @@
// Debounce state and press classification, one item per cycle while the output register is free or being drained.
module bpc_core
  import bpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  stage_t  stage,
  output result_t result
);

  logic        pressed;
  logic [31:0] press_time;
  logic [31:0] last_edge_time;
  logic        release_pending;
  logic [31:0] release_time;

  logic        pressed_next;
  logic [31:0] press_time_next;
  logic [31:0] last_edge_time_next;
  logic        release_pending_next;
  logic [31:0] release_time_next;

  logic [31:0] edge_gap;
  logic [31:0] release_gap;
  logic [31:0] duration;
  logic [31:0] debounce_wide;
  logic [31:0] long_wide;

  assign debounce_wide = {16'd0, cfg.debounce_ms};
  assign long_wide     = {16'd0, cfg.long_press_ms};
  assign edge_gap      = stage.item.now_ms - last_edge_time;
  assign release_gap   = stage.item.now_ms - release_time;
  assign duration      = release_time - press_time;

  always_comb begin
    pressed_next         = pressed;
    press_time_next      = press_time;
    last_edge_time_next  = last_edge_time;
    release_pending_next = release_pending;
    release_time_next    = release_time;
    result.valid         = 1'b0;
    result.press_event   = PRESS_SHORT;
    if (stage.fire) begin
      case (stage.item.kind)
        KIND_EDGE: begin
          if (edge_gap >= debounce_wide) begin
            last_edge_time_next = stage.item.now_ms;
            if (stage.item.pin_level) begin
              press_time_next = stage.item.now_ms;
              pressed_next    = 1'b1;
            end
          end
        end
        KIND_POLL: begin
          if (pressed) begin
            if (stage.item.pin_level) begin
              release_pending_next = 1'b0;
            end else if (!release_pending) begin
              release_pending_next = 1'b1;
              release_time_next    = stage.item.now_ms;
            end else if (release_gap >= debounce_wide) begin
              pressed_next         = 1'b0;
              release_pending_next = 1'b0;
              if (duration >= long_wide) begin
                result.valid       = 1'b1;
                result.press_event = PRESS_LONG;
              end else if (duration >= debounce_wide) begin
                result.valid       = 1'b1;
                result.press_event = PRESS_SHORT;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed         <= 1'b0;
      press_time      <= 32'd0;
      last_edge_time  <= 32'd0;
      release_pending <= 1'b0;
      release_time    <= 32'd0;
    end else begin
      pressed         <= pressed_next;
      press_time      <= press_time_next;
      last_edge_time  <= last_edge_time_next;
      release_pending <= release_pending_next;
      release_time    <= release_time_next;
    end
  end

  a_pending_needs_press: assert property (@(posedge clk) disable iff (rst)
    release_pending |-> pressed)
    else $error("release candidate without an active press");

  a_result_ends_press: assert property (@(posedge clk) disable iff (rst)
    result.valid |=> !pressed && !release_pending)
    else $error("press still active after its result");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !stage.fire |=> $stable(pressed) && $stable(last_edge_time) && $stable(release_pending))
    else $error("state changed without an item");

  a_result_from_poll: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> stage.item.kind == KIND_POLL && !stage.item.pin_level && pressed)
    else $error("result from an item that cannot end a press");

endmodule

@@ design/bpc_out_stage.sv @@
// Output register that holds one press result item until it is taken.
module bpc_out_stage
  import bpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  result_t    result,
  bpc_press_if.source press,
  output logic       out_free
);

  logic valid;
  logic press_event;

  assign out_free          = !valid || press.ready;
  assign press.valid       = valid;
  assign press.press_event = press_event;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (result.valid) begin
      valid <= 1'b1;
    end else if (press.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      press_event <= result.press_event;
    end
  end

endmodule

@@ design/button_press_classifier.sv @@
// Top level of the debounced short/long button press classifier.
//
// The sample channel carries edge and poll items (kind, now_ms, pin_level);
// the press channel returns one press_event item (0 short, 1 long) when a
// poll confirms the end of a press lasting at least debounce_ms. Edge items
// and most polls give no result. Thresholds sit behind the APB port:
// debounce_ms at byte address 0, long_press_ms at byte address 4.
//
// An accepted item is held in the input register, where the state update
// and classification run, and any result is then registered in the output
// register. One item per cycle is accepted while the output register is
// free or being drained. When the receiver holds ready low with a result
// waiting, the input register fills and sample.ready drops until it drains.
// Reset clears the press state, the edge time and both registers, and sets
// debounce_ms to 30 and long_press_ms to 800.
module button_press_classifier
  import bpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  bpc_sample_if.sink  sample,
  bpc_press_if.source press,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  stage_t  stage;
  result_t result;
  logic    out_free;

  bpc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpc_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .out_free (out_free),
    .stage    (stage)
  );

  bpc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .stage  (stage),
    .result (result)
  );

  bpc_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .result   (result),
    .press    (press),
    .out_free (out_free)
  );

endmodule
